FILE: hdl/rat_pkg.sv
// Package for the relative-age text parser: phase type, unit word tables, constants.
package rat_pkg;

  localparam int          AGE_W     = 63;
  localparam int          SECS_W    = 25;
  localparam int          NUM_UNITS = 7;
  localparam logic [62:0] MAX63     = {63{1'b1}};

  typedef enum logic [5:0] {
    PH_LEAD   = 6'b000001,
    PH_DIGITS = 6'b000010,
    PH_GAP    = 6'b000100,
    PH_UNIT   = 6'b001000,
    PH_DONE   = 6'b010000,
    PH_FAIL   = 6'b100000
  } phase_t;

  // Unit words, left justified and zero padded to six letters.
  function automatic logic [47:0] unit_word(input logic [2:0] k);
    logic [47:0] w;
    case (k)
      3'd0:    w = "second";
      3'd1:    w = "minute";
      3'd2:    w = {"hour", 16'h0000};
      3'd3:    w = {"day", 24'h000000};
      3'd4:    w = {"week", 16'h0000};
      3'd5:    w = {"month", 8'h00};
      3'd6:    w = {"year", 16'h0000};
      default: w = 48'h0;
    endcase
    return w;
  endfunction

  function automatic logic [7:0] unit_letter(input logic [2:0] k, input logic [2:0] pos);
    logic [47:0] w;
    logic [7:0]  ch;
    w = unit_word(k);
    case (pos)
      3'd0:    ch = w[47:40];
      3'd1:    ch = w[39:32];
      3'd2:    ch = w[31:24];
      3'd3:    ch = w[23:16];
      3'd4:    ch = w[15:8];
      3'd5:    ch = w[7:0];
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  function automatic logic [2:0] unit_len(input logic [2:0] k);
    logic [2:0] n;
    case (k)
      3'd0:    n = 3'd6;
      3'd1:    n = 3'd6;
      3'd2:    n = 3'd4;
      3'd3:    n = 3'd3;
      3'd4:    n = 3'd4;
      3'd5:    n = 3'd5;
      3'd6:    n = 3'd4;
      default: n = 3'd0;
    endcase
    return n;
  endfunction

  function automatic logic [SECS_W-1:0] unit_secs(input logic [2:0] k);
    logic [SECS_W-1:0] s;
    case (k)
      3'd0:    s = 25'd1;
      3'd1:    s = 25'd60;
      3'd2:    s = 25'd3600;
      3'd3:    s = 25'd86400;
      3'd4:    s = 25'd604800;
      3'd5:    s = 25'd2592000;
      3'd6:    s = 25'd31536000;
      default: s = 25'd0;
    endcase
    return s;
  endfunction

endpackage

FILE: hdl/relative_age_text_parser_top.sv
// Relative-age text parser: characters in, age in seconds out on each phrase's last request.
//
// Usage
//   Input channel (in_valid / in_stall): one request per phrase character.
//   in_has_char = 0 carries no character (an empty phrase when it is also
//   the last request); in_is_last closes the phrase and produces one result.
//   Result channel (out_valid / out_stall): age in seconds, a recognized flag
//   and a saturated flag, one result per phrase.
// Path: a phrase's result passes the input register, the parse stage into
//   stage 1, the partial products in stage 2, then the result register.
// Throughput: one request per cycle while in_stall is low; the parse state turns over
//   to the next phrase in the cycle after a last character.
// Reset: rst_n low clears all stage valid bits and returns the parser to the
//   leading whitespace phase.
// Stall: a stalled result holds in the output register; the pipeline behind
//   it keeps filling until each stage holds a request, then in_stall rises.
//   Requests that are not the last of a phrase drain through the parse
//   stage even while the result side is blocked.
module relative_age_text_parser_top (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [7:0]                in_text_char,
  input  logic                      in_has_char,
  input  logic                      in_is_last,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [rat_pkg::AGE_W-1:0] out_age_seconds,
  output logic                      out_recognized,
  output logic                      out_saturated
);
  import rat_pkg::*;

  // Stage ready chain, back from the result register.
  logic rdy3, rdy2, rdy1, rdy0;
  logic fire0;

  // Input register
  logic       v0_r;
  logic [7:0] s0_char_r;
  logic       s0_has_r;
  logic       s0_last_r;

  // Parse state
  phase_t      phase_r, phase_nxt;
  logic [62:0] amount_r, amount_nxt;
  logic        too_big_r, too_big_nxt;
  logic [6:0]  cand_r, cand_nxt;
  logic [2:0]  upos_r, upos_nxt;
  logic [2:0]  unit_r, unit_nxt;

  // Stage 1: amount and unit of a finished phrase
  logic        v1_r;
  logic [62:0] s1_amount_r;
  logic [2:0]  s1_unit_r;
  logic        s1_rec_r;

  // Stage 2: partial products
  logic        v2_r;
  logic [56:0] s2_pp_lo_r;
  logic [55:0] s2_pp_hi_r;
  logic        s2_rec_r;

  // Output register
  logic        out_valid_r;
  logic [62:0] out_age_r;
  logic        out_rec_r;
  logic        out_sat_r;

  assign rdy3  = !out_valid_r || !out_stall;
  assign rdy2  = !v2_r || rdy3;
  assign rdy1  = !v1_r || rdy2;
  // A request that is not last leaves no result, so it needs no room in stage 1.
  assign rdy0  = !v0_r || !s0_last_r || rdy1;
  assign fire0 = v0_r && (!s0_last_r || rdy1);
  assign in_stall = !rdy0;

  // ------------------------------------------------------------------
  // Input register
  // ------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else if (rdy0) begin
      v0_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy0 && in_valid) begin
      s0_char_r <= in_text_char;
      s0_has_r  <= in_has_char;
      s0_last_r <= in_is_last;
    end
  end

  // ------------------------------------------------------------------
  // Parse: one character against the phase state
  // ------------------------------------------------------------------
  logic [7:0]  ch;
  logic        is_digit, is_ws, is_space;
  logic [66:0] wide;
  logic [6:0]  keep;
  logic        word_done;
  logic [2:0]  word_unit;
  logic        rec_nxt;

  always_comb begin
    ch = s0_char_r;
    // Lowercase A..Z.
    if (s0_char_r >= 8'h41 && s0_char_r <= 8'h5A) begin
      ch = s0_char_r + 8'h20;
    end
    is_digit = (ch >= 8'h30) && (ch <= 8'h39);
    is_space = (ch == 8'h20);
    is_ws    = is_space || ((ch >= 8'h09) && (ch <= 8'h0D));
    // amount * 10 + digit, wide enough to see the overflow
    wide = {1'b0, amount_r, 3'b000} + {3'b000, amount_r, 1'b0} + {63'd0, ch[3:0]};

    // Compare against every still-possible unit word; lowest index wins a finish.
    keep      = 7'd0;
    word_done = 1'b0;
    word_unit = unit_r;
    for (int k = NUM_UNITS - 1; k >= 0; k--) begin
      if (cand_r[k] && (upos_r < unit_len(3'(k))) && (unit_letter(3'(k), upos_r) == ch)) begin
        keep[k] = 1'b1;
        if (upos_r + 3'd1 == unit_len(3'(k))) begin
          word_done = 1'b1;
          word_unit = 3'(k);
        end
      end
    end
  end

  // Apply a unit-word character to the next state.
  function automatic void unit_step(
    input  logic       done,
    input  logic [6:0] kp,
    input  logic [2:0] wu,
    input  logic [2:0] pos,
    inout  phase_t     ph,
    inout  logic [6:0] cnd,
    inout  logic [2:0] up,
    inout  logic [2:0] un
  );
    if (done) begin
      un = wu;
      ph = PH_DONE;
    end else if (kp == 7'd0) begin
      ph = PH_FAIL;
    end else begin
      cnd = kp;
      up  = pos + 3'd1;
    end
  endfunction

  always_comb begin
    phase_nxt   = phase_r;
    amount_nxt  = amount_r;
    too_big_nxt = too_big_r;
    cand_nxt    = cand_r;
    upos_nxt    = upos_r;
    unit_nxt    = unit_r;
    if (s0_has_r) begin
      case (phase_r)
        PH_LEAD: begin
          if (is_digit) begin
            phase_nxt = PH_DIGITS;
            if (!too_big_r) begin
              if (|wide[66:63]) too_big_nxt = 1'b1;
              else              amount_nxt  = wide[62:0];
            end
          end else if (!is_ws) begin
            phase_nxt = PH_FAIL;
          end
        end
        PH_DIGITS: begin
          if (is_digit) begin
            if (!too_big_r) begin
              if (|wide[66:63]) too_big_nxt = 1'b1;
              else              amount_nxt  = wide[62:0];
            end
          end else if (is_space) begin
            phase_nxt = PH_GAP;
          end else begin
            phase_nxt = PH_UNIT;
            unit_step(word_done, keep, word_unit, upos_r,
                      phase_nxt, cand_nxt, upos_nxt, unit_nxt);
          end
        end
        PH_GAP: begin
          if (!is_space) begin
            phase_nxt = PH_UNIT;
            unit_step(word_done, keep, word_unit, upos_r,
                      phase_nxt, cand_nxt, upos_nxt, unit_nxt);
          end
        end
        PH_UNIT: begin
          unit_step(word_done, keep, word_unit, upos_r,
                    phase_nxt, cand_nxt, upos_nxt, unit_nxt);
        end
        default: begin
        end
      endcase
    end
    rec_nxt = (phase_nxt == PH_DONE) && !too_big_nxt && (amount_nxt != 63'd0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_LEAD;
      amount_r  <= 63'd0;
      too_big_r <= 1'b0;
      cand_r    <= 7'h7F;
      upos_r    <= 3'd0;
      unit_r    <= 3'd0;
    end else if (fire0) begin
      if (s0_last_r) begin
        // Phrase closed: start over for the next one.
        phase_r   <= PH_LEAD;
        amount_r  <= 63'd0;
        too_big_r <= 1'b0;
        cand_r    <= 7'h7F;
        upos_r    <= 3'd0;
        unit_r    <= 3'd0;
      end else begin
        phase_r   <= phase_nxt;
        amount_r  <= amount_nxt;
        too_big_r <= too_big_nxt;
        cand_r    <= cand_nxt;
        upos_r    <= upos_nxt;
        unit_r    <= unit_nxt;
      end
    end
  end

  // ------------------------------------------------------------------
  // Stage 1: hold a finished phrase
  // ------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (rdy1) begin
      v1_r <= fire0 && s0_last_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1 && fire0 && s0_last_r) begin
      // Drop the amount of a failed phrase so the product comes out zero.
      s1_amount_r <= rec_nxt ? amount_nxt : 63'd0;
      s1_unit_r   <= unit_nxt;
      s1_rec_r    <= rec_nxt;
    end
  end

  // ------------------------------------------------------------------
  // Stage 2: amount x unit length as two partial products
  // ------------------------------------------------------------------
  logic [SECS_W-1:0] secs;
  logic [56:0]       pp_lo_nxt;
  logic [55:0]       pp_hi_nxt;

  assign secs      = unit_secs(s1_unit_r);
  assign pp_lo_nxt = s1_amount_r[31:0] * secs;
  assign pp_hi_nxt = s1_amount_r[62:32] * secs;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (rdy2) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy2 && v1_r) begin
      s2_pp_lo_r <= pp_lo_nxt;
      s2_pp_hi_r <= pp_hi_nxt;
      s2_rec_r   <= s1_rec_r;
    end
  end

  // ------------------------------------------------------------------
  // Output register: sum the partial products and clamp
  // ------------------------------------------------------------------
  logic [87:0] prod;
  logic        sat_nxt;

  assign prod    = {s2_pp_hi_r, 32'd0} + {31'd0, s2_pp_lo_r};
  assign sat_nxt = |prod[87:63];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (rdy3) begin
      out_valid_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy3 && v2_r) begin
      out_age_r <= sat_nxt ? MAX63 : prod[62:0];
      out_rec_r <= s2_rec_r;
      out_sat_r <= sat_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_age_seconds = out_age_r;
  assign out_recognized  = out_rec_r;
  assign out_saturated   = out_sat_r;

`ifndef SYNTHESIS
  a_sat_needs_rec: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_sat_r |-> out_rec_r)
    else $error("saturated result without recognition");

  a_fail_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_rec_r |-> out_age_r == 63'd0)
    else $error("unrecognized phrase gave a nonzero age");

  a_restart: assert property (@(posedge clk) disable iff (!rst_n)
    fire0 && s0_last_r |=> phase_r == PH_LEAD && amount_r == 63'd0 && cand_r == 7'h7F)
    else $error("parser did not restart after a last character");

  a_cand_live: assert property (@(posedge clk) disable iff (!rst_n)
    cand_r != 7'd0)
    else $error("unit candidate set went empty");
`endif

endmodule

FILE: sim/relative_age_text_parser_top_test.sv
// Testbench for the relative-age text parser: random phrases checked against a built-in parser.
`timescale 1ns / 100ps

module relative_age_text_parser_top_test;
  import rat_pkg::*;

  localparam int CLK_HALF       = 2;
  localparam int RESET_CYCLES   = 10;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int HOLDOFF_CYCLES = 300;
  localparam int DRAIN_CYCLES   = 8;
  localparam int CHARS_PER_MIX  = 382;
  localparam int PCT_HEAVY      = 86;
  localparam int PCT_BOTH       = 37;
  localparam int NUM_WORDS      = 7;
  localparam longint unsigned AGE_MAX = 64'h7FFF_FFFF_FFFF_FFFF;

  // One request on the character channel.
  typedef struct packed {
    logic [7:0] ch;
    logic       has;
    logic       last;
  } char_req_t;

  // One parsed age as it should leave the block.
  typedef struct packed {
    logic [AGE_W-1:0] age;
    logic             rec;
    logic             sat;
  } age_result_t;

  logic             clk          = 1'b0;
  logic             rst_n        = 1'b0;
  logic             in_valid     = 1'b0;
  logic             in_stall;
  logic [7:0]       in_text_char = 8'h00;
  logic             in_has_char  = 1'b0;
  logic             in_is_last   = 1'b0;
  logic             out_valid;
  logic             out_stall    = 1'b0;
  logic [AGE_W-1:0] out_age_seconds;
  logic             out_recognized;
  logic             out_saturated;

  // Unit words and their lengths in seconds, index order as the block counts them.
  string           unit_names    [NUM_WORDS] = '{"second", "minute", "hour", "day",
                                                 "week", "month", "year"};
  longint unsigned unit_secs_tab [NUM_WORDS] = '{64'd1, 64'd60, 64'd3600, 64'd86400,
                                                 64'd604800, 64'd2592000, 64'd31536000};

  // Parser state mirrored by the testbench.
  phase_t          parse_phase;
  longint unsigned amount_value;
  bit              amount_overflow;
  logic [6:0]      unit_pool;
  int              unit_pos;
  int              unit_hit;

  char_req_t   char_queue    [$];
  age_result_t expected_ages [$];
  logic [7:0]  phrase_bytes  [$];

  int  stim_chars         = 0;
  int  chars_taken        = 0;
  int  ages_checked       = 0;
  int  recognized_seen    = 0;
  int  saturated_seen     = 0;
  int  error_count        = 0;
  int  idle_cycles        = 0;
  int  sender_idle_pct    = 0;
  int  receiver_stall_pct = 0;
  int  holdoff_asked      = 0;
  int  holdoff_served     = 0;
  int  holdoff_left       = 0;
  bit  char_taken         = 1'b0;
  char_req_t next_req;

  relative_age_text_parser_top i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_text_char    (in_text_char),
    .in_has_char     (in_has_char),
    .in_is_last      (in_is_last),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_age_seconds (out_age_seconds),
    .out_recognized  (out_recognized),
    .out_saturated   (out_saturated)
  );

  always #CLK_HALF clk = ~clk;

  // ---------------------------------------------------------------------------
  // Parse predictor
  // ---------------------------------------------------------------------------

  // Return the parser to the leading whitespace phase with nothing collected.
  function automatic void clear_parse();
    parse_phase     = PH_LEAD;
    amount_value    = 0;
    amount_overflow = 1'b0;
    unit_pool       = '1;
    unit_pos        = 0;
    unit_hit        = 0;
  endfunction

  // Append one decimal digit; once the amount no longer fits in 63 bits, latch the overflow.
  function automatic void take_digit(input logic [7:0] c);
    longint unsigned d;
    d = longint'(c - "0");
    if (!amount_overflow) begin
      if (amount_value > (AGE_MAX - d) / 10) begin
        amount_overflow = 1'b1;
      end else begin
        amount_value = amount_value * 10 + d;
      end
    end
  endfunction

  // Narrow the set of unit words still possible; finish on the first complete word.
  function automatic void match_unit_letter(input logic [7:0] c);
    logic [6:0] keep;
    bit         hit;
    keep = '0;
    hit  = 1'b0;
    for (int k = 0; k < NUM_WORDS; k++) begin
      if (!hit && unit_pool[k] && unit_pos < unit_names[k].len()
          && unit_names[k][unit_pos] == c) begin
        keep[k] = 1'b1;
        if (unit_pos + 1 == unit_names[k].len()) begin
          unit_hit    = k;
          parse_phase = PH_DONE;
          hit         = 1'b1;
        end
      end
    end
    if (!hit) begin
      if (keep == '0) begin
        parse_phase = PH_FAIL;
      end else begin
        unit_pool = keep;
        unit_pos  = (unit_pos + 1) & 7;
      end
    end
  endfunction

  // Advance the parser by one accepted request; a last request queues the age it closes.
  function automatic void parse_request(input logic [7:0] raw, input logic has,
                                        input logic last);
    logic [7:0]      c;
    age_result_t     r;
    longint unsigned secs;
    c = raw;
    if (has) begin
      if (c >= "A" && c <= "Z") c = c + 8'd32;
      case (parse_phase)
        PH_LEAD: begin
          if (c == " " || (c >= 8'd9 && c <= 8'd13)) begin
            // skip leading whitespace
          end else if (c >= "0" && c <= "9") begin
            parse_phase = PH_DIGITS;
            take_digit(c);
          end else begin
            parse_phase = PH_FAIL;
          end
        end
        PH_DIGITS: begin
          if (c >= "0" && c <= "9") begin
            take_digit(c);
          end else if (c == " ") begin
            parse_phase = PH_GAP;
          end else begin
            parse_phase = PH_UNIT;
            match_unit_letter(c);
          end
        end
        PH_GAP: begin
          if (c != " ") begin
            parse_phase = PH_UNIT;
            match_unit_letter(c);
          end
        end
        PH_UNIT: match_unit_letter(c);
        default: ;
      endcase
    end
    if (last) begin
      r = '0;
      if (parse_phase == PH_DONE && !amount_overflow && amount_value != 0) begin
        secs  = unit_secs_tab[unit_hit];
        r.rec = 1'b1;
        if (amount_value > AGE_MAX / secs) begin
          r.age = MAX63;
          r.sat = 1'b1;
        end else begin
          r.age = AGE_W'(amount_value * secs);
        end
      end
      expected_ages.push_back(r);
      clear_parse();
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Phrase generation
  // ---------------------------------------------------------------------------

  // Turn phrase_bytes into requests. An empty phrase becomes one last request without a
  // character. Unless plain, sprinkle in no-character requests that change nothing, and
  // now and then close the phrase with a separate last request that carries no character.
  task automatic queue_phrase(input bit plain);
    char_req_t r;
    bit        closer;
    closer = !plain && phrase_bytes.size() > 0 && $urandom_range(9) == 0;
    if (phrase_bytes.size() == 0) begin
      r.ch   = 8'($urandom_range(255));
      r.has  = 1'b0;
      r.last = 1'b1;
      char_queue.push_back(r);
      stim_chars++;
    end
    foreach (phrase_bytes[i]) begin
      if (!plain && $urandom_range(99) < 4) begin
        r.ch   = 8'($urandom_range(255));
        r.has  = 1'b0;
        r.last = 1'b0;
        char_queue.push_back(r);
      end
      r.ch   = phrase_bytes[i];
      r.has  = 1'b1;
      r.last = !closer && (i == phrase_bytes.size() - 1);
      char_queue.push_back(r);
      stim_chars++;
    end
    if (closer) begin
      r.ch   = 8'($urandom_range(255));
      r.has  = 1'b0;
      r.last = 1'b1;
      char_queue.push_back(r);
      stim_chars++;
    end
  endtask

  task automatic queue_text(input string s);
    phrase_bytes.delete();
    for (int i = 0; i < s.len(); i++) phrase_bytes.push_back(s[i]);
    queue_phrase(1'b1);
  endtask

  // Build one random phrase. Most are well formed ("<ws><digits><spaces><unit><tail>")
  // with random case and amounts aimed at zero, the product clamp and the 63-bit
  // amount limit; a share carries one flaw, and a few are raw byte noise.
  task automatic build_phrase();
    int              kind;
    int              flaw;
    int              pick;
    int              k;
    int              wlen;
    int              bad;
    int              n;
    longint unsigned amt;
    logic [7:0]      c;
    logic [7:0]      digits [$];
    string           tail_text;
    phrase_bytes.delete();
    kind = $urandom_range(99);
    if (kind < 8) begin
      n = $urandom_range(0, 8);
      repeat (n) phrase_bytes.push_back(8'($urandom_range(255)));
    end else begin
      // flaws: 1 no digits, 2 tab in the gap, 3 word cut short, 4 wrong letter
      flaw = (kind < 28) ? $urandom_range(1, 4) : 0;
      k    = $urandom_range(NUM_WORDS - 1);
      repeat ($urandom_range(0, 2)) begin
        n = $urandom_range(8, 13);
        phrase_bytes.push_back((n == 8) ? 8'h20 : 8'(n));
      end
      if (flaw != 1) begin
        if ($urandom_range(99) < 15) begin
          repeat ($urandom_range(1, 2)) phrase_bytes.push_back("0");
        end
        pick = $urandom_range(99);
        if (pick >= 94) begin
          // far past 63 bits
          phrase_bytes.push_back(8'("1" + $urandom_range(8)));
          repeat ($urandom_range(19, 21)) phrase_bytes.push_back(8'("0" + $urandom_range(9)));
        end else begin
          if (pick < 52)      amt = $urandom_range(1, 999);
          else if (pick < 60) amt = 0;
          else if (pick < 74) amt = AGE_MAX / unit_secs_tab[k] + $urandom_range(4) - 2;
          else if (pick < 82) amt = AGE_MAX + $urandom_range(3) - 1;
          else                amt = {$urandom, $urandom} % 64'd1_000_000_000_000;
          digits.delete();
          do begin
            digits.push_front(8'("0" + amt % 10));
            amt = amt / 10;
          end while (amt != 0);
          foreach (digits[i]) phrase_bytes.push_back(digits[i]);
        end
      end
      if (flaw == 2) begin
        repeat ($urandom_range(0, 1)) phrase_bytes.push_back(" ");
        phrase_bytes.push_back(8'h09);
      end else begin
        n = $urandom_range(99);
        repeat ((n < 20) ? 0 : (n < 85) ? 1 : $urandom_range(2, 3)) phrase_bytes.push_back(" ");
      end
      wlen = (flaw == 3) ? $urandom_range(0, unit_names[k].len() - 1) : unit_names[k].len();
      bad  = (flaw == 4) ? $urandom_range(0, unit_names[k].len() - 1) : -1;
      for (int p = 0; p < wlen; p++) begin
        c = unit_names[k][p];
        if (p == bad) c = 8'("a" + $urandom_range(25));
        if ($urandom_range(1)) c = c - 8'd32;
        phrase_bytes.push_back(c);
      end
      if (flaw != 3) begin
        case ($urandom_range(3))
          0: ;
          1: phrase_bytes.push_back("s");
          2: begin
            tail_text = "s ago";
            foreach (tail_text[i]) phrase_bytes.push_back(tail_text[i]);
          end
          default: repeat ($urandom_range(1, 4)) phrase_bytes.push_back(8'($urandom_range(255)));
        endcase
      end
    end
    queue_phrase(1'b0);
  endtask

  // ---------------------------------------------------------------------------
  // Character driver: change inputs on the falling edge, hold a stalled request
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (rst_n && (!in_valid || char_taken)) begin
      if (char_queue.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
        next_req     = char_queue.pop_front();
        in_valid     <= 1'b1;
        in_text_char <= next_req.ch;
        in_has_char  <= next_req.has;
        in_is_last   <= next_req.last;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result receiver: random stalls, plus a long hold-off on request
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (holdoff_left > 0) begin
      holdoff_left = holdoff_left - 1;
      out_stall    <= 1'b1;
    end else if (holdoff_served != holdoff_asked) begin
      // hold the result side off long enough for the block to back up into in_stall
      holdoff_served = holdoff_asked;
      holdoff_left   = HOLDOFF_CYCLES - 1;
      out_stall      <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < receiver_stall_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: sample at the rising edge, predict on accepted requests, check results
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      char_taken = 1'b0;
    end else begin
      char_taken = in_valid && !in_stall;
      if (char_taken) begin
        parse_request(in_text_char, in_has_char, in_is_last);
        chars_taken++;
      end
      if (out_valid && !out_stall) begin
        ages_checked++;
        if (out_recognized) recognized_seen++;
        if (out_saturated) saturated_seen++;
        if (expected_ages.size() == 0) begin
          $display("%0t: unexpected result: age %0d recognized %0b saturated %0b",
                   $time, out_age_seconds, out_recognized, out_saturated);
          error_count++;
        end else begin
          automatic age_result_t want = expected_ages.pop_front();
          if (out_age_seconds !== want.age) begin
            $display("%0t: age_seconds expected %0d, got %0d", $time, want.age,
                     out_age_seconds);
            error_count++;
          end
          if (out_recognized !== want.rec) begin
            $display("%0t: recognized expected %0b, got %0b", $time, want.rec,
                     out_recognized);
            error_count++;
          end
          if (out_saturated !== want.sat) begin
            $display("%0t: saturated expected %0b, got %0b", $time, want.sat,
                     out_saturated);
            error_count++;
          end
        end
      end
      if (char_taken || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
    end
  end

  // Watchdog: drop the run if neither channel moves for too long.
  initial begin
    while (idle_cycles < WATCHDOG_LIMIT) @(negedge clk);
    $display("%0t: timeout, no request moved for %0d cycles, %0d results outstanding",
             $time, WATCHDOG_LIMIT, expected_ages.size());
    $display("*** FAILED ***");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Sequencing
  // ---------------------------------------------------------------------------

  // Advance until every queued request is taken and every predicted result has come out.
  task automatic wait_drained();
    while (char_queue.size() != 0 || in_valid || expected_ages.size() != 0) @(negedge clk);
  endtask

  // Run one mix of sender idling and receiver stalling over a fresh batch of phrases.
  task automatic run_random_mix(input int sender_pct, input int receiver_pct,
                                input bit with_holdoff);
    int target;
    @(posedge clk);
    sender_idle_pct    = sender_pct;
    receiver_stall_pct = receiver_pct;
    target             = stim_chars + CHARS_PER_MIX;
    while (stim_chars < target) build_phrase();
    if (with_holdoff) holdoff_asked++;
    wait_drained();
  endtask

  initial begin
    char_req_t r;
    clear_parse();
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty phrase, a lone no-character request, whitespace then digits with
    // a mixed-case word, amount zero, a tab in the gap, an unknown word, a non-ASCII
    // byte, and a phrase that ends inside the word.
    r = '{ch: 8'hFF, has: 1'b0, last: 1'b1};
    char_queue.push_back(r);
    stim_chars++;
    r = '{ch: 8'hA5, has: 1'b0, last: 1'b0};
    char_queue.push_back(r);
    queue_text("\v7Day");
    queue_text("0 year");
    queue_text("3\tm");
    queue_text("9z");
    phrase_bytes.delete();
    phrase_bytes.push_back(8'hC8);
    queue_phrase(1'b1);
    queue_text("12 h");
    wait_drained();

    // Random: full speed with one long result hold-off, then sender idling, receiver
    // stalling, and both together.
    run_random_mix(0, 0, 1'b1);
    run_random_mix(PCT_HEAVY, 0, 1'b0);
    run_random_mix(0, PCT_HEAVY, 1'b0);
    run_random_mix(PCT_BOTH, PCT_BOTH, 1'b0);

    // Let the pipeline run a little longer so a stray extra result would still be caught.
    receiver_stall_pct = 0;
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("Parsed %0d characters into %0d phrases: %0d recognized, %0d clamped.",
             chars_taken, ages_checked, recognized_seen, saturated_seen);
    $display("Mixes: full speed with a %0d-cycle hold-off, idle sender, stalling receiver, both.",
             HOLDOFF_CYCLES);
    if (error_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches", error_count);
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
